[hw/rtl/pressure_wave_phase_planner_defines.svh]
// assertion macros shared by the pressure wave phase planner rtl
// expects clk and rst in the scope of each use
`ifndef PRESSURE_WAVE_PHASE_PLANNER_DEFINES_SVH
`define PRESSURE_WAVE_PHASE_PLANNER_DEFINES_SVH

// same-cycle implication
`define PWPP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PWPP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/pwpp_pkg.sv]
// shared types and constants of the pressure wave phase planner
// no dependencies
`timescale 1ns / 1ps

package pwpp_pkg;

  // cycle window and fallback split
  localparam int unsigned CYCLE_MS_DEF   = 60000;
  localparam int unsigned EQUAL_SPLIT_MS = 20000;

  // widths
  localparam int DUR_W      = 24;             // durations and positions
  localparam int TOT_W      = 26;             // sum of three durations, divisor
  localparam int DIV_W      = 48;             // divider dividend
  localparam int CNT_W      = 6;              // divider step count
  localparam int PEAK_W     = 16;
  localparam int PER_W      = 16;
  localparam int OUT_W      = 16;
  localparam int ELAPSED_W  = 32;
  localparam int TPROD_W    = PEAK_W + DUR_W; // peak times position
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 88;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 24;
  localparam int QUEUE_DEPTH = 2;             // power of two

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_RISE_TIME    = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_HOLD_TIME    = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_PULSE_TIME   = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_PEAK         = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_PULSE_PERIOD = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_PULSE_ON     = 3'd5;

  // phase codes
  localparam logic [1:0] PH_RISE      = 2'd0;
  localparam logic [1:0] PH_HOLD      = 2'd1;
  localparam logic [1:0] PH_PULSE_ON  = 2'd2;
  localparam logic [1:0] PH_PULSE_OFF = 2'd3;

  // gain stage codes
  localparam logic [1:0] GAIN_RISE  = 2'd0;
  localparam logic [1:0] GAIN_HOLD  = 2'd1;
  localparam logic [1:0] GAIN_PULSE = 2'd2;

  typedef struct packed {
    logic [DUR_W-1:0]  rise_time_ms;
    logic [DUR_W-1:0]  hold_time_ms;
    logic [DUR_W-1:0]  pulse_time_ms;
    logic [PEAK_W-1:0] peak_pressure;
    logic [PER_W-1:0]  pulse_period_ms;
    logic [PER_W-1:0]  pulse_on_ms;
  } cfg_t;

  typedef struct packed {
    logic [1:0]        phase;
    logic [OUT_W-1:0]  target_pressure;
    logic              inflating;
    logic [1:0]        gain_stage;
    logic [OUT_W-1:0]  cycle_position_ms;
    logic [OUT_W-1:0]  rise_span_ms;
    logic [OUT_W-1:0]  hold_span_ms;
    logic [OUT_W-1:0]  pulse_span_ms;
  } result_t;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [TOT_W-1:0]  divisor;
    logic [CNT_W-1:0]  steps;
  } div_ctl_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DIV_W-1:0]  quot;
    logic [TOT_W-1:0]  rem;
  } div_stat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_POS_GO,
    ST_POS_WAIT,
    ST_SCALE,
    ST_RISE_GO,
    ST_RISE_WAIT,
    ST_HOLD_GO,
    ST_HOLD_WAIT,
    ST_SPLIT,
    ST_CLASSIFY,
    ST_TAIL_GO,
    ST_TAIL_WAIT,
    ST_DONE
  } state_t;

endpackage

[hw/rtl/pressure_wave_phase_planner.sv]
// top level of the pressure wave phase planner: config registers, queue and back end
// depends on pwpp_pkg, pwpp_queue and pwpp_back
`timescale 1ns / 1ps

// Takes one elapsed time in ms per transfer and returns one result per item: the
// phase (rise, hold, pulse on, pulse off), the Q8.8 target pressure, the inflate,
// valve and pump flags, the gain stage, the position within the CYCLE_MS window
// and the three scaled spans. The position within the window comes from a
// compare and subtract of shifted window lengths, four per clock. The two span
// divisions, the rise ramp and the pulse remainder share one restoring divider
// that retires one quotient bit per clock: a 48-bit quotient for each span,
// then a 40-bit one in rise or a 24-bit one in the pulse stage. When all
// durations are zero the span divisions are skipped.
// A two-entry input queue and an output register let inputs arrive and results
// drain while an item is being worked. Configuration writes take effect at once
// and should only be made while no item is in flight.

module pressure_wave_phase_planner #(
  parameter int unsigned CYCLE_MS = pwpp_pkg::CYCLE_MS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [pwpp_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // [31:0] elapsed_ms
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [1:0] phase, [17:2] target_pressure, [18] inflating, [19] open_valve,
  // [20] pump_enable, [22:21] gain_stage, [38:23] cycle_position_ms,
  // [54:39] rise_span_ms, [70:55] hold_span_ms, [86:71] pulse_span_ms, [87] zero
  output logic [pwpp_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                            cfg_we,
  input  logic [pwpp_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [pwpp_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import pwpp_pkg::*;

  cfg_t                 cfg;
  logic                 q_valid;
  logic [IN_DATA_W-1:0] q_data;
  logic                 q_pop;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rise_time_ms    <= DUR_W'(20000);
      cfg.hold_time_ms    <= DUR_W'(20000);
      cfg.pulse_time_ms   <= DUR_W'(20000);
      cfg.peak_pressure   <= '0;
      cfg.pulse_period_ms <= PER_W'(2000);
      cfg.pulse_on_ms     <= PER_W'(1000);
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_RISE_TIME:    cfg.rise_time_ms    <= cfg_wdata[DUR_W-1:0];
        REG_HOLD_TIME:    cfg.hold_time_ms    <= cfg_wdata[DUR_W-1:0];
        REG_PULSE_TIME:   cfg.pulse_time_ms   <= cfg_wdata[DUR_W-1:0];
        REG_PEAK:         cfg.peak_pressure   <= cfg_wdata[PEAK_W-1:0];
        REG_PULSE_PERIOD: cfg.pulse_period_ms <= cfg_wdata[PER_W-1:0];
        REG_PULSE_ON:     cfg.pulse_on_ms     <= cfg_wdata[PER_W-1:0];
        default: ;
      endcase
    end
  end

  pwpp_queue u_queue (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .q_valid       (q_valid),
    .q_data        (q_data),
    .q_pop         (q_pop)
  );

  pwpp_back #(
    .CYCLE_MS (CYCLE_MS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .q_valid       (q_valid),
    .q_data        (q_data),
    .q_pop         (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

[hw/rtl/pwpp_queue.sv]
// front part: input stream slave and a short queue of elapsed times
// depends on pwpp_pkg
`timescale 1ns / 1ps

module pwpp_queue (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [pwpp_pkg::IN_DATA_W-1:0] s_axis_tdata,   // [31:0] elapsed_ms
  output logic                           q_valid,
  output logic [pwpp_pkg::IN_DATA_W-1:0] q_data,
  input  logic                           q_pop
);
  import pwpp_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

  logic [IN_DATA_W-1:0] slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]     wr_ptr;
  logic [PTR_W-1:0]     rd_ptr;
  logic [FILL_W-1:0]    fill;
  logic                 push;

  assign s_axis_tready = (fill != FILL_W'(QUEUE_DEPTH));
  assign push          = s_axis_tvalid && s_axis_tready;
  assign q_valid       = (fill != '0);
  assign q_data        = slots[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !q_pop) begin
        fill <= fill + 1'b1;
      end else if (!push && q_pop) begin
        fill <= fill - 1'b1;
      end
    end
  end

  // slot storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= s_axis_tdata;
    end
  end

endmodule

[hw/rtl/pwpp_div.sv]
// shared restoring divider, one quotient bit per cycle
// depends on pwpp_pkg
`timescale 1ns / 1ps

module pwpp_div (
  input  logic                clk,
  input  logic                rst,
  input  pwpp_pkg::div_ctl_t  ctl,
  output pwpp_pkg::div_stat_t stat
);
  import pwpp_pkg::*;

  logic [DIV_W-1:0] num;
  logic [TOT_W-1:0] rem;
  logic [DIV_W-1:0] quot;
  logic [TOT_W-1:0] divisor;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;
  logic [TOT_W:0]   trial;
  logic [TOT_W:0]   diff;
  logic             ge;

  // one trial subtraction per step, dividend enters msb first
  assign trial = {rem, num[DIV_W-1]};
  assign ge    = (trial >= {1'b0, divisor});
  assign diff  = trial - {1'b0, divisor};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        cnt  <= ctl.steps;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      num     <= ctl.dividend;
      divisor <= ctl.divisor;
      rem     <= '0;
      quot    <= '0;
    end else if (busy) begin
      num  <= {num[DIV_W-2:0], 1'b0};
      rem  <= ge ? diff[TOT_W-1:0] : trial[TOT_W-1:0];
      quot <= {quot[DIV_W-2:0], ge};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign stat.quot = quot;
  assign stat.rem  = rem;

endmodule

[hw/rtl/pwpp_back.sv]
// back part: span scaling, phase classification and result register
// depends on pwpp_pkg, pwpp_div and the assertion macro header
`timescale 1ns / 1ps
`include "pressure_wave_phase_planner_defines.svh"

module pwpp_back #(
  parameter int unsigned CYCLE_MS = pwpp_pkg::CYCLE_MS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  pwpp_pkg::cfg_t                  cfg,
  input  logic                            q_valid,
  input  logic [pwpp_pkg::IN_DATA_W-1:0]  q_data,
  output logic                            q_pop,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [pwpp_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import pwpp_pkg::*;

  localparam logic [DUR_W-1:0] CYC   = DUR_W'(CYCLE_MS);
  localparam logic [DUR_W-1:0] SPLIT = DUR_W'(EQUAL_SPLIT_MS);

  // cycle position: compare and subtract of shifted window lengths, msb first
  localparam int POS_SH_TOP   = ELAPSED_W - $clog2(CYCLE_MS + 1);
  localparam int POS_PER_CYC  = 4;
  localparam int POS_ROUNDS   = (POS_SH_TOP + POS_PER_CYC) / POS_PER_CYC;
  localparam int RED_W        = ELAPSED_W + DUR_W;
  localparam int SH_W         = $clog2(ELAPSED_W + POS_PER_CYC);
  localparam logic [SH_W-1:0] POS_SH_FIRST = SH_W'(POS_ROUNDS * POS_PER_CYC - 1);
  localparam logic [SH_W-1:0] POS_SH_LAST  = SH_W'(POS_PER_CYC - 1);

  state_t            state;
  state_t            state_next;
  div_ctl_t          div_ctl;
  div_stat_t         div_stat;

  logic [ELAPSED_W-1:0] elapsed;
  logic [ELAPSED_W-1:0] red_acc;
  logic [ELAPSED_W-1:0] red_val;
  logic [RED_W-1:0]     red_mul;
  logic [SH_W-1:0]      red_sh;
  logic [DUR_W-1:0]  pos;
  logic [DUR_W-1:0]  rs;
  logic [DUR_W-1:0]  hs;
  logic [DUR_W-1:0]  ps;
  logic [DIV_W-1:0]  prod_r;
  logic [DIV_W-1:0]  prod_h;
  logic [TOT_W-1:0]  total;
  logic [DIV_W-1:0]  tail_dividend;
  logic [TOT_W-1:0]  tail_divisor;
  logic [CNT_W-1:0]  tail_steps;
  result_t           res;
  result_t           out_res;

  logic [TOT_W-1:0]  tot_sum;
  logic [DUR_W:0]    sum_rh;
  logic [DUR_W:0]    span_sum;
  logic [DUR_W-1:0]  pulse_offset;
  logic [TPROD_W-1:0] tprod;
  logic [PER_W-1:0]  per;
  logic              pulse_hit;
  logic              out_free;

  pwpp_div u_div (
    .clk  (clk),
    .rst  (rst),
    .ctl  (div_ctl),
    .stat (div_stat)
  );

  // shared arithmetic
  assign tot_sum   = TOT_W'(cfg.rise_time_ms) + TOT_W'(cfg.hold_time_ms)
                   + TOT_W'(cfg.pulse_time_ms);
  assign sum_rh    = {1'b0, rs} + {1'b0, hs};
  assign span_sum  = sum_rh + {1'b0, ps};
  assign pulse_offset = DUR_W'({1'b0, pos} - sum_rh);
  assign tprod     = TPROD_W'(cfg.peak_pressure) * TPROD_W'(pos);
  assign per       = (cfg.pulse_period_ms == '0) ? PER_W'(1) : cfg.pulse_period_ms;
  assign pulse_hit = (div_stat.rem < TOT_W'(cfg.pulse_on_ms));
  assign out_free  = !m_axis_tvalid || m_axis_tready;

  // one round of the cycle position reduction
  always_comb begin
    red_val = red_acc;
    red_mul = '0;
    for (int j = 0; j < POS_PER_CYC; j++) begin
      red_mul = RED_W'(CYCLE_MS) << (red_sh - SH_W'(j));
      if ({{DUR_W{1'b0}}, red_val} >= red_mul) begin
        red_val = red_val - red_mul[ELAPSED_W-1:0];
      end
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:      if (q_valid) state_next = ST_POS_GO;
      ST_POS_GO:    state_next = ST_POS_WAIT;
      ST_POS_WAIT:  if (red_sh == POS_SH_LAST) state_next = ST_SCALE;
      ST_SCALE: begin
        state_next = (tot_sum == '0) ? ST_CLASSIFY : ST_RISE_GO;
      end
      ST_RISE_GO:   state_next = ST_RISE_WAIT;
      ST_RISE_WAIT: if (div_stat.done) state_next = ST_HOLD_GO;
      ST_HOLD_GO:   state_next = ST_HOLD_WAIT;
      ST_HOLD_WAIT: if (div_stat.done) state_next = ST_SPLIT;
      ST_SPLIT:     state_next = ST_CLASSIFY;
      ST_CLASSIFY: begin
        if (({1'b0, pos} < sum_rh) && (pos >= rs)) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_TAIL_GO;
        end
      end
      ST_TAIL_GO:   state_next = ST_TAIL_WAIT;
      ST_TAIL_WAIT: if (div_stat.done) state_next = ST_DONE;
      ST_DONE:      if (out_free) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // outputs: queue pop and divider requests
  always_comb begin
    q_pop            = 1'b0;
    div_ctl.start    = 1'b0;
    div_ctl.dividend = tail_dividend;
    div_ctl.divisor  = tail_divisor;
    div_ctl.steps    = tail_steps;
    case (state)
      ST_IDLE: q_pop = q_valid;
      ST_RISE_GO: begin
        div_ctl.start    = 1'b1;
        div_ctl.dividend = prod_r;
        div_ctl.divisor  = total;
        div_ctl.steps    = CNT_W'(DIV_W);
      end
      ST_HOLD_GO: begin
        div_ctl.start    = 1'b1;
        div_ctl.dividend = prod_h;
        div_ctl.divisor  = total;
        div_ctl.steps    = CNT_W'(DIV_W);
      end
      ST_TAIL_GO: div_ctl.start = 1'b1;
      default: ;
    endcase
  end

  // working registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: elapsed <= q_data;
      ST_POS_GO: begin
        red_acc <= elapsed;
        red_sh  <= POS_SH_FIRST;
      end
      ST_POS_WAIT: begin
        red_acc <= red_val;
        red_sh  <= red_sh - SH_W'(POS_PER_CYC);
        if (red_sh == POS_SH_LAST) pos <= red_val[DUR_W-1:0];
      end
      ST_SCALE: begin
        prod_r <= DIV_W'(cfg.rise_time_ms) * DIV_W'(CYC);
        prod_h <= DIV_W'(cfg.hold_time_ms) * DIV_W'(CYC);
        total  <= tot_sum;
        if (tot_sum == '0) begin
          rs <= SPLIT;
          hs <= SPLIT;
          ps <= SPLIT;
        end
      end
      ST_RISE_WAIT: begin
        if (div_stat.done) rs <= div_stat.quot[DUR_W-1:0];
      end
      ST_HOLD_WAIT: begin
        if (div_stat.done) hs <= div_stat.quot[DUR_W-1:0];
      end
      // rise and hold may reach the window: clip hold, or rise alone, and drop the pulse span
      ST_SPLIT: begin
        if (sum_rh >= {1'b0, CYC}) begin
          ps <= '0;
          if (rs >= CYC) begin
            rs <= CYC;
            hs <= '0;
          end else begin
            hs <= CYC - rs;
          end
        end else begin
          ps <= CYC - sum_rh[DUR_W-1:0];
        end
      end
      ST_CLASSIFY: begin
        res.cycle_position_ms <= pos[OUT_W-1:0];
        res.rise_span_ms      <= rs[OUT_W-1:0];
        res.hold_span_ms      <= hs[OUT_W-1:0];
        res.pulse_span_ms     <= ps[OUT_W-1:0];
        if (pos < rs) begin
          // ramp: peak * pos / rise span
          res.phase      <= PH_RISE;
          res.gain_stage <= GAIN_RISE;
          res.inflating  <= 1'b1;
          tail_dividend  <= {tprod, {(DIV_W-TPROD_W){1'b0}}};
          tail_divisor   <= TOT_W'(rs);
          tail_steps     <= CNT_W'(TPROD_W);
        end else if ({1'b0, pos} < sum_rh) begin
          res.phase           <= PH_HOLD;
          res.gain_stage      <= GAIN_HOLD;
          res.inflating       <= 1'b1;
          res.target_pressure <= cfg.peak_pressure;
        end else begin
          // pulse: offset into the stage modulo the period
          res.phase      <= PH_PULSE_OFF;
          res.gain_stage <= GAIN_PULSE;
          res.inflating  <= 1'b0;
          tail_dividend  <= {pulse_offset, {(DIV_W-DUR_W){1'b0}}};
          tail_divisor   <= TOT_W'(per);
          tail_steps     <= CNT_W'(DUR_W);
        end
      end
      ST_TAIL_WAIT: begin
        if (div_stat.done) begin
          if (res.phase == PH_RISE) begin
            res.target_pressure <= div_stat.quot[OUT_W-1:0];
          end else begin
            res.phase           <= pulse_hit ? PH_PULSE_ON : PH_PULSE_OFF;
            res.inflating       <= pulse_hit;
            res.target_pressure <= pulse_hit ? cfg.peak_pressure : '0;
          end
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if ((state == ST_DONE) && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_DONE) && out_free) begin
      out_res <= res;
    end
  end

  // pack result, highest field first
  assign m_axis_tdata = {1'b0, out_res.pulse_span_ms, out_res.hold_span_ms,
                         out_res.rise_span_ms, out_res.cycle_position_ms,
                         out_res.gain_stage, out_res.inflating, out_res.inflating,
                         out_res.inflating, out_res.target_pressure, out_res.phase};

  `PWPP_ASSERT_IMP(a_div_free, div_ctl.start, !div_stat.busy, "divider started while busy")
  `PWPP_ASSERT_NXT(a_out_load, (state == ST_DONE) && out_free, m_axis_tvalid, "result not loaded")
  `PWPP_ASSERT_IMP(a_span_fill, (state == ST_CLASSIFY) && (total != '0) && (tot_sum != '0), span_sum == {1'b0, CYC}, "spans do not fill the cycle")

endmodule

[bench/pressure_wave_phase_planner_tb.sv]
// testbench of the pressure wave phase planner: directed and random elapsed times
// under several duration, peak and pulse settings; depends on pwpp_pkg and the rtl
`timescale 1ns / 1ps

module pressure_wave_phase_planner_tb;
  import pwpp_pkg::*;

  localparam int unsigned CYC = 60000;
  localparam int WATCHDOG_LIMIT = 20000;

  // lowest field last, matching the result tdata layout
  typedef struct packed {
    logic [15:0] pulse_span_ms;
    logic [15:0] hold_span_ms;
    logic [15:0] rise_span_ms;
    logic [15:0] cycle_position_ms;
    logic [1:0]  gain_stage;
    logic        pump_enable;
    logic        open_valve;
    logic        inflating;
    logic [15:0] target_pressure;
    logic [1:0]  phase;
  } plan_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // shadow copy of the configuration
  logic [23:0] rise_ms, hold_ms, pulse_len_ms;
  logic [15:0] peak, period_ms, on_ms;

  plan_t pending_plans[$];
  int errors = 0;
  int results_seen = 0;
  int idle_cycles = 0;
  bit calm = 1'b0;
  bit timed_out = 1'b0;

  pressure_wave_phase_planner DUT (.*);

  initial begin
    forever #10 clk = ~clk;
  end

  // expected plan for one elapsed time
  function automatic plan_t plan_for(logic [31:0] elapsed);
    plan_t p;
    longint unsigned r, h, s, tot, pos, per, q;
    bit on;
    r = 64'(rise_ms);
    h = 64'(hold_ms);
    s = 64'(pulse_len_ms);
    tot = r + h + s;
    if (tot == 0) begin
      r = 64'(EQUAL_SPLIT_MS);
      h = 64'(EQUAL_SPLIT_MS);
      s = 64'(EQUAL_SPLIT_MS);
    end else begin
      r = r * CYC / tot;
      h = h * CYC / tot;
      if (r + h >= CYC) begin
        if (r >= CYC) begin
          r = 64'(CYC);
          h = 0;
        end else begin
          h = CYC - r;
        end
        s = 0;
      end else begin
        s = CYC - r - h;
      end
    end
    pos = 64'(elapsed) % CYC;
    if (pos < r) begin
      p.phase = PH_RISE;
      p.target_pressure = 16'((64'(peak) * pos) / r);
      p.inflating = 1'b1;
      p.gain_stage = GAIN_RISE;
    end else if (pos < r + h) begin
      p.phase = PH_HOLD;
      p.target_pressure = peak;
      p.inflating = 1'b1;
      p.gain_stage = GAIN_HOLD;
    end else begin
      per = (period_ms == '0) ? 64'd1 : 64'(period_ms);
      q = (pos - r - h) % per;
      on = q < 64'(on_ms);
      p.phase = on ? PH_PULSE_ON : PH_PULSE_OFF;
      p.target_pressure = on ? peak : 16'd0;
      p.inflating = on;
      p.gain_stage = GAIN_PULSE;
    end
    p.open_valve = p.inflating;
    p.pump_enable = p.inflating;
    p.cycle_position_ms = 16'(pos);
    p.rise_span_ms = 16'(r);
    p.hold_span_ms = 16'(h);
    p.pulse_span_ms = 16'(s);
    return p;
  endfunction

  // result side: random stalls, field by field compare
  always @(posedge clk) begin
    plan_t got, want;
    if (!rst) begin
      m_axis_tready <= calm ? 1'b1 : ($urandom_range(99) >= 16);
      if (m_axis_tvalid && m_axis_tready) begin
        got = plan_t'(m_axis_tdata[86:0]);
        results_seen++;
        if (pending_plans.size() == 0) begin
          $error("result with no expectation waiting");
          errors++;
        end else begin
          want = pending_plans.pop_front();
          if (got.phase !== want.phase) begin
            $error("phase exp %0d got %0d", want.phase, got.phase); errors++;
          end
          if (got.target_pressure !== want.target_pressure) begin
            $error("target_pressure exp %0d got %0d", want.target_pressure,
                   got.target_pressure); errors++;
          end
          if (got.inflating !== want.inflating) begin
            $error("inflating exp %0d got %0d", want.inflating, got.inflating); errors++;
          end
          if (got.open_valve !== want.open_valve) begin
            $error("open_valve exp %0d got %0d", want.open_valve, got.open_valve); errors++;
          end
          if (got.pump_enable !== want.pump_enable) begin
            $error("pump_enable exp %0d got %0d", want.pump_enable, got.pump_enable);
            errors++;
          end
          if (got.gain_stage !== want.gain_stage) begin
            $error("gain_stage exp %0d got %0d", want.gain_stage, got.gain_stage); errors++;
          end
          if (got.cycle_position_ms !== want.cycle_position_ms) begin
            $error("cycle_position_ms exp %0d got %0d", want.cycle_position_ms,
                   got.cycle_position_ms); errors++;
          end
          if (got.rise_span_ms !== want.rise_span_ms) begin
            $error("rise_span_ms exp %0d got %0d", want.rise_span_ms, got.rise_span_ms);
            errors++;
          end
          if (got.hold_span_ms !== want.hold_span_ms) begin
            $error("hold_span_ms exp %0d got %0d", want.hold_span_ms, got.hold_span_ms);
            errors++;
          end
          if (got.pulse_span_ms !== want.pulse_span_ms) begin
            $error("pulse_span_ms exp %0d got %0d", want.pulse_span_ms, got.pulse_span_ms);
            errors++;
          end
        end
      end
    end
  end

  // watchdog on cycles with no transfer
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        timed_out = 1'b1;
      end
    end
  end

  // send one elapsed time, with a random gap first; valid stays up afterwards
  task automatic send_elapsed(logic [31:0] elapsed);
    if (!calm) begin
      while ($urandom_range(99) < 16) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= elapsed;
    pending_plans.push_back(plan_for(elapsed));
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // stop sending, wait for all results, then let the block settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_plans.size() != 0) @(posedge clk);
    repeat (250) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [23:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_RISE_TIME:    rise_ms = val;
      REG_HOLD_TIME:    hold_ms = val;
      REG_PULSE_TIME:   pulse_len_ms = val;
      REG_PEAK:         peak = val[15:0];
      REG_PULSE_PERIOD: period_ms = val[15:0];
      REG_PULSE_ON:     on_ms = val[15:0];
      default: ;
    endcase
  endtask

  task automatic set_all(logic [23:0] r, logic [23:0] h, logic [23:0] s,
                         logic [15:0] pk, logic [15:0] per, logic [15:0] on);
    write_reg(REG_RISE_TIME, r);
    write_reg(REG_HOLD_TIME, h);
    write_reg(REG_PULSE_TIME, s);
    write_reg(REG_PEAK, 24'(pk));
    write_reg(REG_PULSE_PERIOD, 24'(per));
    write_reg(REG_PULSE_ON, 24'(on));
  endtask

  // cycle boundaries, field extremes and phase edges under reset settings, then under other settings
  task automatic test_directed();
    send_elapsed(32'd0);
    send_elapsed(32'hFFFF_FFFF);
    send_elapsed(32'd19999);
    send_elapsed(32'd20000);
    send_elapsed(32'd39999);
    send_elapsed(32'd40000);
    send_elapsed(32'd40999);
    send_elapsed(32'd41000);
    send_elapsed(32'd59999);
    send_elapsed(32'd60000);
    drain();
    // all durations zero, max peak
    set_all(24'd0, 24'd0, 24'd0, 16'hFFFF, 16'd0, 16'd0);
    send_elapsed(32'd10000);
    send_elapsed(32'd45000);
    drain();
    write_reg(REG_PULSE_ON, 24'd5);
    send_elapsed(32'd45001);
    drain();
    // widest durations, rise only, on not shorter than period
    set_all(24'hFFFFFF, 24'd0, 24'd0, 16'h8000, 16'd7, 16'hFFFF);
    send_elapsed(32'd59999);
    send_elapsed(32'd12345);
    drain();
    set_all(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 16'd1, 16'hFFFF, 16'd1);
    send_elapsed(32'd59999);
    send_elapsed(32'd40000);
    send_elapsed(32'd40001);
    drain();
    // hold only and pulse only
    set_all(24'd0, 24'd5, 24'd0, 16'd300, 16'd1, 16'd0);
    send_elapsed(32'd777);
    drain();
    set_all(24'd0, 24'd0, 24'd9, 16'd300, 16'd3, 16'd1);
    send_elapsed(32'd778);
    send_elapsed(32'd779);
    drain();
  endtask

  task automatic random_settings();
    case ($urandom_range(3))
      0: set_all(24'($urandom), 24'($urandom), 24'($urandom),
                 16'($urandom), 16'($urandom), 16'($urandom));
      1: set_all(24'($urandom_range(50000)), 24'($urandom_range(50000)),
                 24'($urandom_range(50000)), 16'($urandom),
                 16'($urandom_range(3000)), 16'($urandom_range(3000)));
      2: set_all(24'($urandom_range(3)), 24'($urandom_range(3)), 24'($urandom_range(3)),
                 16'($urandom), 16'($urandom_range(9)), 16'($urandom_range(9)));
      default: set_all($urandom_range(1) ? 24'hFFFFFF : 24'd0, 24'($urandom_range(100)),
                       24'($urandom), 16'hFFFF, $urandom_range(1) ? 16'hFFFF : 16'd1,
                       16'($urandom));
    endcase
  endtask

  // random phases, each under a fresh setting
  task automatic test_random();
    for (int ph = 0; ph < 26; ph++) begin
      random_settings();
      calm = (ph == 5);
      for (int i = 0; i < 50; i++) begin
        if (i == 25 && ph == 3) begin
          drain();
        end
        send_elapsed($urandom_range(1) ? $urandom : $urandom_range(CYC - 1));
      end
      drain();
    end
    calm = 1'b0;
  endtask

  initial begin
    rise_ms = 24'd20000;
    hold_ms = 24'd20000;
    pulse_len_ms = 24'd20000;
    peak = 16'd0;
    period_ms = 16'd2000;
    on_ms = 16'd1000;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random();
    drain();
    $display("covered %0d results over directed edges and 26 random settings,",
             results_seen);
    $display("including zero, widest and degenerate durations and pulse patterns");
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    wait (timed_out);
    $display("FAILED: results differ");
    $finish;
  end

endmodule
